// ===== sv/egcd_pkg.sv =====
// Shared types and constants for the extended gcd / modular inverse block.
package egcd_pkg;

  // Fixed port field widths
  localparam int unsigned FieldBits = 31;
  localparam int unsigned CoefBits  = 32;

  // One request: operand and modulus
  typedef struct packed {
    logic [FieldBits-1:0] value_a;
    logic [FieldBits-1:0] modulus;
  } in_t;

  // One result
  typedef struct packed {
    logic [FieldBits-1:0]       gcd_result;
    logic signed [CoefBits-1:0] coef_a;
    logic signed [CoefBits-1:0] coef_m;
    logic [FieldBits-1:0]       inverse;
    logic                       has_inverse;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic div_init;  // start a division r0 / r1
    logic div_step;  // one restoring division bit
    logic update;    // rotate remainders and coefficients
    logic reduce;    // form the inverse and flag
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic r1_zero;   // current divisor is zero: loop finished
  } sts_t;

endpackage

// ===== sv/egcd_ctrl.sv =====
// Sequencer for the Euclid loop: check, divide bit by bit, update, reduce, hand off.
module egcd_ctrl #(
  parameter int unsigned W = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  egcd_pkg::sts_t    sts_i,
  output egcd_pkg::cmd_t    cmd_o
);

  localparam int unsigned CntBits = $clog2(W);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StUpdate = 3'd3;
  localparam logic [2:0] StReduce = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.r1_zero) begin
          state_d = StReduce;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntBits'(W - 1)) begin
          state_d = StUpdate;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StCheck;
      end
      StReduce: begin
        cmd_o.reduce = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/egcd_dp.sv =====
// Datapath: remainders, Bezout coefficients, restoring divider with shift-add products.
module egcd_dp #(
  parameter int unsigned W = 31
) (
  input  logic            clk_i,
  input  egcd_pkg::in_t   in_data_i,
  input  egcd_pkg::cmd_t  cmd_i,
  output egcd_pkg::sts_t  sts_o,
  output egcd_pkg::out_t  result_o
);

  logic [W-1:0]        r0_q, r1_q, m_q;
  logic signed [W:0]   s0_q, s1_q, t0_q, t1_q;
  logic [W-1:0]        rem_q, dq_q;
  logic [W:0]          acc_s_q, acc_t_q;
  logic [W-1:0]        inv_q;
  logic                flag_q;

  logic [W:0]          shifted, diff;
  logic                qbit;
  logic [W+1:0]        s_w, m_w, red;

  // One restoring division bit
  assign shifted = {rem_q, dq_q[W-1]};
  assign diff    = shifted - {1'b0, r1_q};
  assign qbit    = ~diff[W];

  // Bring s0 into 0..m-1
  assign s_w = {s0_q[W], s0_q};
  assign m_w = {2'b00, m_q};
  always_comb begin
    priority if (s_w[W+1]) begin
      red = s_w + m_w;
    end else if (s_w >= m_w) begin
      red = s_w - m_w;
    end else begin
      red = s_w;
    end
  end

  assign sts_o.r1_zero = (r1_q == '0);

  // Advance datapath registers on command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q <= in_data_i.value_a[W-1:0];
      r1_q <= in_data_i.modulus[W-1:0];
      m_q  <= in_data_i.modulus[W-1:0];
      s0_q <= (W+1)'(1);
      s1_q <= '0;
      t0_q <= '0;
      t1_q <= (W+1)'(1);
    end
    if (cmd_i.div_init) begin
      rem_q   <= '0;
      dq_q    <= r0_q;
      acc_s_q <= '0;
      acc_t_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q   <= qbit ? diff[W-1:0] : shifted[W-1:0];
      dq_q    <= {dq_q[W-2:0], qbit};
      acc_s_q <= {acc_s_q[W-1:0], 1'b0} + (qbit ? s1_q : '0);
      acc_t_q <= {acc_t_q[W-1:0], 1'b0} + (qbit ? t1_q : '0);
    end
    if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= rem_q;
      s0_q <= s1_q;
      s1_q <= s0_q - $signed(acc_s_q);
      t0_q <= t1_q;
      t1_q <= t0_q - $signed(acc_t_q);
    end
    if (cmd_i.reduce) begin
      flag_q <= (m_q != '0) && (r0_q == W'(1));
      inv_q  <= ((m_q != '0) && (r0_q == W'(1))) ? red[W-1:0] : '0;
    end
  end

  // Result view of the registers
  assign result_o.gcd_result  = egcd_pkg::FieldBits'(r0_q);
  assign result_o.coef_a      = egcd_pkg::CoefBits'(s0_q);
  assign result_o.coef_m      = egcd_pkg::CoefBits'(t0_q);
  assign result_o.inverse     = egcd_pkg::FieldBits'(inv_q);
  assign result_o.has_inverse = flag_q;

endmodule

// ===== sv/extended_gcd_modular_inverse.sv =====
// Top level of the extended gcd / modular inverse block.
//
//   channel  | signals                              | carries
//   ---------+--------------------------------------+---------------------------
//   request  | in_valid_i / in_ready_o / in_data_i  | value_a, modulus
//   result   | out_valid_o / out_ready_i / out_data_o | gcd, coefficients, inverse
//
// One request at a time. Each Euclid iteration runs a check, a restoring
// division of W bits and an update, W = min(OPERAND_BITS, 31). Reset clears
// the controller and the output valid; there is no clearing pass. A result
// waiting on the output register holds the controller in its done state, so
// the next request is not taken until the waiting result is taken.
module extended_gcd_modular_inverse #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  egcd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output egcd_pkg::out_t  out_data_o
);

  localparam int unsigned UsedBits =
    (OPERAND_BITS < egcd_pkg::FieldBits) ? OPERAND_BITS : egcd_pkg::FieldBits;

  egcd_pkg::cmd_t cmd;
  egcd_pkg::sts_t sts;
  egcd_pkg::out_t result;
  logic           out_free;
  logic           out_valid_q;
  egcd_pkg::out_t out_q;

  assign out_free = ~out_valid_q | out_ready_i;

  egcd_ctrl #(.W(UsedBits)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  egcd_dp #(.W(UsedBits)) u_dp (
    .clk_i     (clk_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .result_o  (result)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/egcd_checker.sv =====
// Port-level checks for the extended gcd block, bound to the top level.
module egcd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input egcd_pkg::out_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // One request in work at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // Flag implies a gcd of one
  a_flag_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_inverse |-> out_data_o.gcd_result == 1)
    else $error("inverse flagged with gcd other than one");

  // No inverse reads as zero
  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_inverse |-> out_data_o.inverse == '0)
    else $error("nonzero inverse without flag");

endmodule

bind extended_gcd_modular_inverse egcd_checker u_egcd_checker (.*);
